@@ design/lr_pkg.sv @@
// lr_pkg: shared types, microcode encodings and the control store of the
// line rasterizer. No dependencies.
package lr_pkg;

  // Microprogram step address
  typedef logic [1:0] step_t;

  localparam step_t STEP_WAIT  = 2'd0;
  localparam step_t STEP_SETUP = 2'd1;
  localparam step_t STEP_INIT  = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  // Datapath operation selected by a control word
  typedef enum logic [1:0] {
    OP_CAPTURE  = 2'd0,
    OP_SETUP    = 2'd1,
    OP_INIT_ERR = 2'd2,
    OP_EMIT     = 2'd3
  } op_t;

  // Branch condition selected by a control word
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_START  = 2'd1,
    COND_LAST   = 2'd2
  } cond_t;

  // One control word: operation, condition, and both successors
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t next_hit;
    step_t next_miss;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic last;
  } dp_flags_t;

  // Control store (read-only)
  function automatic ctrl_t lr_ucode(input step_t addr);
    ctrl_t w;
    case (addr)
      STEP_WAIT: begin
        w = '{op: OP_CAPTURE, cond: COND_START,
              next_hit: STEP_SETUP, next_miss: STEP_WAIT};
      end
      STEP_SETUP: begin
        w = '{op: OP_SETUP, cond: COND_ALWAYS,
              next_hit: STEP_INIT, next_miss: STEP_INIT};
      end
      STEP_INIT: begin
        w = '{op: OP_INIT_ERR, cond: COND_ALWAYS,
              next_hit: STEP_EMIT, next_miss: STEP_EMIT};
      end
      STEP_EMIT: begin
        w = '{op: OP_EMIT, cond: COND_LAST,
              next_hit: STEP_WAIT, next_miss: STEP_EMIT};
      end
      default: begin
        w = '{op: OP_CAPTURE, cond: COND_ALWAYS,
              next_hit: STEP_WAIT, next_miss: STEP_WAIT};
      end
    endcase
    return w;
  endfunction

endpackage

@@ design/lr_sequencer.sv @@
// lr_sequencer: step counter and control store lookup with conditional
// branching. Depends on lr_pkg.
module lr_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lr_pkg::dp_flags_t flags,
  output lr_pkg::ctrl_t     ctrl,
  output logic              busy
);

  lr_pkg::step_t upc_r;
  lr_pkg::step_t upc_nxt;
  logic          cond_hit;

  // Current control word
  assign ctrl = lr_pkg::lr_ucode(upc_r);
  assign busy = (upc_r != lr_pkg::STEP_WAIT);

  // Branch condition evaluation
  always_comb begin
    case (ctrl.cond)
      lr_pkg::COND_ALWAYS: cond_hit = 1'b1;
      lr_pkg::COND_START:  cond_hit = start;
      lr_pkg::COND_LAST:   cond_hit = flags.last;
      default:             cond_hit = 1'b1;
    endcase
  end

  assign upc_nxt = cond_hit ? ctrl.next_hit : ctrl.next_miss;

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= lr_pkg::STEP_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

@@ design/lr_datapath.sv @@
// lr_datapath: endpoint capture, axis/order setup, error term and cell
// stepper with registered result word. Depends on lr_pkg.
module lr_datapath #(
  parameter int GRID_BITS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lr_pkg::ctrl_t        ctrl,
  input  logic [GRID_BITS-1:0] x_start,
  input  logic [GRID_BITS-1:0] y_start,
  input  logic [GRID_BITS-1:0] x_end,
  input  logic [GRID_BITS-1:0] y_end,
  output lr_pkg::dp_flags_t    flags,
  output logic                 out_valid,
  output logic [GRID_BITS-1:0] cell_x,
  output logic [GRID_BITS-1:0] cell_y,
  output logic                 last_cell
);

  localparam int EW = GRID_BITS + 3;

  // Captured endpoints
  logic [GRID_BITS-1:0] xa_r, ya_r, xb_r, yb_r;
  // Stepper state
  logic [GRID_BITS-1:0] major_pos_r, major_pos_nxt;
  logic [GRID_BITS-1:0] minor_pos_r, minor_pos_nxt;
  logic [GRID_BITS-1:0] major_stop_r, major_stop_nxt;
  logic [GRID_BITS-1:0] span_major_r, span_major_nxt;
  logic [GRID_BITS-1:0] span_minor_r, span_minor_nxt;
  logic                 minor_down_r, minor_down_nxt;
  logic                 steep_r, steep_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  // Result word
  logic                 out_valid_r, out_valid_nxt;
  logic [GRID_BITS-1:0] cell_x_r, cell_x_nxt;
  logic [GRID_BITS-1:0] cell_y_r, cell_y_nxt;
  logic                 last_r, last_nxt;

  // Setup terms
  logic [GRID_BITS-1:0] dx, dy, ma, na, mb, nb;
  logic                 steep_w, swap;
  logic signed [EW-1:0] smin_ext, smaj_ext;
  logic                 at_last;

  assign at_last     = (major_pos_r == major_stop_r);
  assign flags.last  = at_last;

  // Axis selection and endpoint ordering
  always_comb begin
    dx      = (xa_r > xb_r) ? (xa_r - xb_r) : (xb_r - xa_r);
    dy      = (ya_r > yb_r) ? (ya_r - yb_r) : (yb_r - ya_r);
    steep_w = (dy > dx);
    ma      = steep_w ? ya_r : xa_r;
    na      = steep_w ? xa_r : ya_r;
    mb      = steep_w ? yb_r : xb_r;
    nb      = steep_w ? xb_r : yb_r;
    swap    = (ma > mb);
  end

  assign smin_ext = signed'({{3{1'b0}}, span_minor_r});
  assign smaj_ext = signed'({{3{1'b0}}, span_major_r});

  // Next-state logic per micro-operation
  always_comb begin
    major_pos_nxt  = major_pos_r;
    minor_pos_nxt  = minor_pos_r;
    major_stop_nxt = major_stop_r;
    span_major_nxt = span_major_r;
    span_minor_nxt = span_minor_r;
    minor_down_nxt = minor_down_r;
    steep_nxt      = steep_r;
    err_nxt        = err_r;
    out_valid_nxt  = 1'b0;
    cell_x_nxt     = cell_x_r;
    cell_y_nxt     = cell_y_r;
    last_nxt       = last_r;
    case (ctrl.op)
      lr_pkg::OP_CAPTURE: begin
      end
      lr_pkg::OP_SETUP: begin
        steep_nxt      = steep_w;
        major_pos_nxt  = swap ? mb : ma;
        major_stop_nxt = swap ? ma : mb;
        minor_pos_nxt  = swap ? nb : na;
        span_major_nxt = swap ? (ma - mb) : (mb - ma);
        span_minor_nxt = (na > nb) ? (na - nb) : (nb - na);
        // minor decreases when the far end lies below the near end
        minor_down_nxt = swap ? (na < nb) : (nb < na);
      end
      lr_pkg::OP_INIT_ERR: begin
        err_nxt = (smin_ext <<< 1) - smaj_ext;
      end
      lr_pkg::OP_EMIT: begin
        out_valid_nxt = 1'b1;
        cell_x_nxt    = steep_r ? minor_pos_r : major_pos_r;
        cell_y_nxt    = steep_r ? major_pos_r : minor_pos_r;
        last_nxt      = at_last;
        if (err_r > 0) begin
          minor_pos_nxt = minor_down_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
          err_nxt       = err_r + ((smin_ext - smaj_ext) <<< 1);
        end else begin
          err_nxt       = err_r + (smin_ext <<< 1);
        end
        if (!at_last) begin
          major_pos_nxt = major_pos_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Endpoint capture while waiting; the value present at start is kept
  always_ff @(posedge clk) begin
    if (ctrl.op == lr_pkg::OP_CAPTURE) begin
      xa_r <= x_start;
      ya_r <= y_start;
      xb_r <= x_end;
      yb_r <= y_end;
    end
  end

  // Stepper and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      major_pos_r  <= '0;
      minor_pos_r  <= '0;
      major_stop_r <= '0;
      span_major_r <= '0;
      span_minor_r <= '0;
      minor_down_r <= 1'b0;
      steep_r      <= 1'b0;
      err_r        <= '0;
      cell_x_r     <= '0;
      cell_y_r     <= '0;
      last_r       <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      major_pos_r  <= major_pos_nxt;
      minor_pos_r  <= minor_pos_nxt;
      major_stop_r <= major_stop_nxt;
      span_major_r <= span_major_nxt;
      span_minor_r <= span_minor_nxt;
      minor_down_r <= minor_down_nxt;
      steep_r      <= steep_nxt;
      err_r        <= err_nxt;
      cell_x_r     <= cell_x_nxt;
      cell_y_r     <= cell_y_nxt;
      last_r       <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cell_x    = cell_x_r;
  assign cell_y    = cell_y_r;
  assign last_cell = last_r;

endmodule

@@ design/line_rasterizer.sv @@
// line_rasterizer: top level of the Bresenham line stepper.
// Depends on lr_pkg, lr_sequencer and lr_datapath.
//
// Usage: drive the two endpoints and raise start; the segment is taken at
// the clock edge where start is high and busy is low. The block then emits
// span_major + 1 cells (span_major is the larger of the column and row
// spans), one per clock, each shown for exactly one cycle with out_valid
// high; the last one carries out_last_cell. The receiver cannot stall, so
// it must take a word every cycle out_valid is high. Between accept and the
// next possible accept (1 to 64 cells at the default grid), the microprogram
// orders the endpoints, seeds the error term, loops in the emit step with
// one cell per pass and then returns to its wait step.
module line_rasterizer #(
  parameter int GRID_BITS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [GRID_BITS-1:0] in_x_start,
  input  logic [GRID_BITS-1:0] in_y_start,
  input  logic [GRID_BITS-1:0] in_x_end,
  input  logic [GRID_BITS-1:0] in_y_end,
  output logic                 out_valid,
  output logic [GRID_BITS-1:0] out_cell_x,
  output logic [GRID_BITS-1:0] out_cell_y,
  output logic                 out_last_cell
);

  lr_pkg::ctrl_t     ctrl;
  lr_pkg::dp_flags_t flags;

  // Control store and step counter
  lr_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Datapath driven by the current control word
  lr_datapath #(
    .GRID_BITS (GRID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .x_start   (in_x_start),
    .y_start   (in_y_start),
    .x_end     (in_x_end),
    .y_end     (in_y_end),
    .flags     (flags),
    .out_valid (out_valid),
    .cell_x    (out_cell_x),
    .cell_y    (out_cell_y),
    .last_cell (out_last_cell)
  );

endmodule
